[rtl/tmcg_pkg.sv]
// Shared definitions for the text-mode character generator.
// Holds the field widths, the item kind codes and the divider constants.
// No dependencies.
package tmcg_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned AddrW   = 11;
  localparam int unsigned DataW   = 8;
  localparam int unsigned LineW   = 9;
  localparam int unsigned ColW    = 5;
  localparam int unsigned PixelW  = 24;
  localparam int unsigned ColorW  = 3;

  // A line is at most 511 and a text row spans at least 16 lines.
  localparam int unsigned RowW    = 5;
  // Glyph row index for up to 16 rows per glyph.
  localparam int unsigned SliceW  = 4;
  // Fixed point shift of the reciprocal used to divide a line number.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned ProdW   = 22;

  typedef enum logic [ActionW-1:0] {
    ACT_CHAR   = 2'd0,
    ACT_ATTR   = 2'd1,
    ACT_FONT   = 2'd2,
    ACT_RENDER = 2'd3
  } action_e;

endpackage

[rtl/tmcg_ram.sv]
// Two-port byte store with one write and one registered read per cycle.
// Depends on tmcg_pkg for the byte width.
module tmcg_ram #(
  parameter int unsigned DEPTH = 768,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tmcg_pkg::DataW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tmcg_pkg::DataW-1:0] rdata_o
);

  logic [tmcg_pkg::DataW-1:0] mem [DEPTH];
  logic [tmcg_pkg::DataW-1:0] rdata_q;

  // The read returns the value held before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tmcg_rowdiv.sv]
// Divides a display line number by the height of one text row in lines.
// Uses a reciprocal multiply; depends on tmcg_pkg for widths.
module tmcg_rowdiv #(
  parameter int unsigned GLYPH_ROWS = 8
) (
  input  logic [tmcg_pkg::LineW-1:0] line_i,
  output logic [tmcg_pkg::RowW-1:0]  row_o
);

  localparam int unsigned RowLines = 2 * GLYPH_ROWS;
  localparam int unsigned Recip    =
    ((1 << tmcg_pkg::RecipShift) + RowLines - 1) / RowLines;

  logic [tmcg_pkg::ProdW-1:0] prod;

  // The rounding error of the reciprocal stays below one step for any 9-bit line.
  assign prod  = tmcg_pkg::ProdW'(line_i) * tmcg_pkg::ProdW'(Recip);
  assign row_o = prod[tmcg_pkg::RecipShift +: tmcg_pkg::RowW];

endmodule

[rtl/tmcg_expand.sv]
// Expands one font byte into eight 3-bit color indices, leftmost pixel first.
// Blanking forces an all-zero row. Depends on tmcg_pkg for widths.
module tmcg_expand (
  input  logic                        blank_i,
  input  logic [tmcg_pkg::DataW-1:0]  font_i,
  input  logic [tmcg_pkg::DataW-1:0]  attr_i,
  output logic [tmcg_pkg::PixelW-1:0] pixel_row_o
);

  logic [tmcg_pkg::ColorW-1:0] fg;
  logic [tmcg_pkg::ColorW-1:0] bg;

  assign fg = attr_i[6:4];
  assign bg = attr_i[2:0];

  always_comb begin
    pixel_row_o = '0;
    for (int i = 0; i < 8; i++) begin
      pixel_row_o[tmcg_pkg::PixelW - 1 - tmcg_pkg::ColorW * i -: tmcg_pkg::ColorW] =
        font_i[7 - i] ? fg : bg;
    end
    if (blank_i) begin
      pixel_row_o = '0;
    end
  end

endmodule

[rtl/text_mode_character_generator_top.sv]
// Text-mode character generator: character, attribute and font stores plus renderer.
// A render beat passes stage A, stage B, stage C and the output register in turn.
// Throughput: one beat per cycle; a beat moves on whenever the stage ahead is free.
// Writes pass stage A only and leave no result. Stage valid bits clear on reset.
// The stores hold no reset value and read as unknown until written.
// Depends on tmcg_pkg, tmcg_rowdiv, tmcg_ram and tmcg_expand.
module text_mode_character_generator_top #(
  parameter int unsigned COLUMNS    = 32,
  parameter int unsigned ROWS       = 24,
  parameter int unsigned GLYPH_ROWS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tmcg_pkg::ActionW-1:0]  action_i,
  input  logic [tmcg_pkg::AddrW-1:0]    address_i,
  input  logic [tmcg_pkg::DataW-1:0]    data_i,
  input  logic [tmcg_pkg::LineW-1:0]    line_i,
  input  logic [tmcg_pkg::ColW-1:0]     column_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmcg_pkg::PixelW-1:0]   pixel_row_o
);

  localparam int unsigned Cells     = COLUMNS * ROWS;
  localparam int unsigned FontBytes = 256 * GLYPH_ROWS;
  localparam int unsigned Lines     = ROWS * 2 * GLYPH_ROWS;
  localparam int unsigned RowLines  = 2 * GLYPH_ROWS;
  localparam int unsigned CellW     = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned FontW     = $clog2(FontBytes);
  localparam int unsigned SumW      = 13;

  // Stage A: registered input beat.
  logic                         a_valid_q;
  tmcg_pkg::action_e            a_action_q;
  logic [tmcg_pkg::AddrW-1:0]   a_address_q;
  logic [tmcg_pkg::DataW-1:0]   a_data_q;
  logic [tmcg_pkg::LineW-1:0]   a_line_q;
  logic [tmcg_pkg::ColW-1:0]    a_column_q;
  logic [tmcg_pkg::RowW-1:0]    a_row_q;
  logic [tmcg_pkg::RowW-1:0]    row_d;

  // Stage B: character and attribute bytes read.
  logic                         b_valid_q;
  logic                         b_oob_q;
  logic [tmcg_pkg::SliceW-1:0]  b_slice_q;
  logic [tmcg_pkg::DataW-1:0]   char_rdata;
  logic [tmcg_pkg::DataW-1:0]   attr_rdata;

  // Stage C: font byte read.
  logic                         c_valid_q;
  logic                         c_oob_q;
  logic [tmcg_pkg::DataW-1:0]   c_attr_q;
  logic [tmcg_pkg::DataW-1:0]   font_rdata;

  // Output register.
  logic                         out_valid_q;
  logic [tmcg_pkg::PixelW-1:0]  pixel_row_q;
  logic [tmcg_pkg::PixelW-1:0]  pixel_row_d;

  logic                         accept;
  logic                         a_free;
  logic                         b_free;
  logic                         c_free;
  logic                         out_free;
  logic                         a_move;
  logic                         a_render;

  logic [SumW-1:0]              cell_sum;
  logic [CellW-1:0]             cell_idx;
  logic [tmcg_pkg::LineW-1:0]   line_rem;
  logic [tmcg_pkg::SliceW-1:0]  slice;
  logic                         oob;
  logic [SumW-1:0]              font_sum;
  logic [FontW-1:0]             font_raddr;

  logic                         char_we;
  logic                         attr_we;
  logic                         font_we;
  logic                         cell_ok;
  logic                         font_ok;

  assign out_free   = !out_valid_q || out_ready_i;
  assign c_free     = !c_valid_q || out_free;
  assign b_free     = !b_valid_q || c_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_ready_o = a_free;
  assign accept     = in_valid_i && a_free;
  assign a_move     = a_valid_q && b_free;
  assign a_render   = a_action_q == tmcg_pkg::ACT_RENDER;

  tmcg_rowdiv #(
    .GLYPH_ROWS(GLYPH_ROWS)
  ) u_rowdiv (
    .line_i(line_i),
    .row_o (row_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_action_q  <= tmcg_pkg::action_e'(action_i);
      a_address_q <= address_i;
      a_data_q    <= data_i;
      a_line_q    <= line_i;
      a_column_q  <= column_i;
      a_row_q     <= row_d;
    end
  end

  assign cell_sum = SumW'(a_row_q) * SumW'(COLUMNS) + SumW'(a_column_q);
  assign cell_idx = CellW'(cell_sum);
  assign line_rem = a_line_q - tmcg_pkg::LineW'(SumW'(a_row_q) * SumW'(RowLines));
  assign slice    = line_rem[tmcg_pkg::SliceW:1];
  assign oob      = (32'(a_line_q) >= 32'(Lines)) || (32'(a_column_q) >= 32'(COLUMNS));

  assign cell_ok  = 32'(a_address_q) < 32'(Cells);
  assign font_ok  = 32'(a_address_q) < 32'(FontBytes);
  assign char_we  = a_move && a_action_q == tmcg_pkg::ACT_CHAR && cell_ok;
  assign attr_we  = a_move && a_action_q == tmcg_pkg::ACT_ATTR && cell_ok;
  assign font_we  = a_move && a_action_q == tmcg_pkg::ACT_FONT && font_ok;

  tmcg_ram #(
    .DEPTH(Cells),
    .AW   (CellW)
  ) u_char_store (
    .clk_i  (clk_i),
    .we_i   (char_we),
    .waddr_i(CellW'(a_address_q)),
    .wdata_i(a_data_q),
    .re_i   (a_move && a_render),
    .raddr_i(cell_idx),
    .rdata_o(char_rdata)
  );

  tmcg_ram #(
    .DEPTH(Cells),
    .AW   (CellW)
  ) u_attr_store (
    .clk_i  (clk_i),
    .we_i   (attr_we),
    .waddr_i(CellW'(a_address_q)),
    .wdata_i(a_data_q),
    .re_i   (a_move && a_render),
    .raddr_i(cell_idx),
    .rdata_o(attr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q && a_render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_oob_q   <= oob;
      b_slice_q <= slice;
    end
  end

  assign font_sum   = SumW'(char_rdata) * SumW'(GLYPH_ROWS) + SumW'(b_slice_q);
  assign font_raddr = FontW'(font_sum);

  tmcg_ram #(
    .DEPTH(FontBytes),
    .AW   (FontW)
  ) u_font_store (
    .clk_i  (clk_i),
    .we_i   (font_we),
    .waddr_i(FontW'(a_address_q)),
    .wdata_i(a_data_q),
    .re_i   (b_valid_q && c_free),
    .raddr_i(font_raddr),
    .rdata_o(font_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_free) begin
      c_oob_q  <= b_oob_q;
      c_attr_q <= attr_rdata;
    end
  end

  tmcg_expand u_expand (
    .blank_i    (c_oob_q),
    .font_i     (font_rdata),
    .attr_i     (c_attr_q),
    .pixel_row_o(pixel_row_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q && out_free) begin
      pixel_row_q <= pixel_row_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_row_o = pixel_row_q;

  // A write beat never turns into a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && !a_render) |=> !b_valid_q)
    else $error("write beat entered the render pipeline");

  // At most one store is written per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({char_we, attr_we, font_we}))
    else $error("more than one store written at once");

  // Input backpressure only when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && b_valid_q && c_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // A stalled glyph row selection holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !c_free) |=> (b_valid_q && $stable(b_slice_q)))
    else $error("stage B changed while stalled");

  // A render outside the screen yields an all-zero pixel row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && c_oob_q && out_free) |=> (out_valid_o && pixel_row_o == '0))
    else $error("off-screen render gave nonzero pixels");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the text-mode character generator.
// Loads the code, attribute and font stores, renders cells and checks each pixel row
// against a local prediction. Depends on tmcg_pkg and text_mode_character_generator_top.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned COLUMNS    = 32;
  localparam int unsigned ROWS       = 24;
  localparam int unsigned GLYPH_ROWS = 8;
  localparam int unsigned CELLS      = COLUMNS * ROWS;
  localparam int unsigned FONT_BYTES = 256 * GLYPH_ROWS;
  localparam int unsigned LINES      = ROWS * 2 * GLYPH_ROWS;
  localparam int unsigned MAX_ADDR   = (1 << tmcg_pkg::AddrW) - 1;
  localparam int unsigned MAX_LINE   = (1 << tmcg_pkg::LineW) - 1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  tmcg_pkg::action_e             action_i;
  logic [tmcg_pkg::AddrW-1:0]    address_i;
  logic [tmcg_pkg::DataW-1:0]    data_i;
  logic [tmcg_pkg::LineW-1:0]    line_i;
  logic [tmcg_pkg::ColW-1:0]     column_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [tmcg_pkg::PixelW-1:0]   pixel_row_o;

  logic [tmcg_pkg::DataW-1:0]    code_mem [CELLS];
  logic [tmcg_pkg::DataW-1:0]    attr_mem [CELLS];
  logic [tmcg_pkg::DataW-1:0]    glyph_mem [FONT_BYTES];
  bit                            code_written [CELLS];
  bit                            attr_written [CELLS];
  bit                            glyph_written [FONT_BYTES];

  logic [tmcg_pkg::PixelW-1:0]   pixel_rows_due [$];
  int unsigned                   mismatch_count;
  int unsigned                   quiet_cycles;
  int unsigned                   send_idle_pct;
  int unsigned                   recv_stall_pct;

  text_mode_character_generator_top #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .GLYPH_ROWS(GLYPH_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .address_i  (address_i),
    .data_i     (data_i),
    .line_i     (line_i),
    .column_i   (column_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_row_o(pixel_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [tmcg_pkg::PixelW-1:0] predict_pixel_row(
      input logic [tmcg_pkg::LineW-1:0] ln, input logic [tmcg_pkg::ColW-1:0] col);
    int unsigned                 cell_idx;
    int unsigned                 slice;
    logic [tmcg_pkg::DataW-1:0]  bits;
    logic [tmcg_pkg::ColorW-1:0] fg;
    logic [tmcg_pkg::ColorW-1:0] bg;
    logic [tmcg_pkg::PixelW-1:0] row;
    if (ln >= LINES || col >= COLUMNS) return '0;
    cell_idx = (ln / (2 * GLYPH_ROWS)) * COLUMNS + col;
    slice    = (ln % (2 * GLYPH_ROWS)) / 2;
    bits     = glyph_mem[code_mem[cell_idx] * GLYPH_ROWS + slice];
    fg       = attr_mem[cell_idx][6:4];
    bg       = attr_mem[cell_idx][2:0];
    row      = '0;
    for (int i = 0; i < 8; i++) begin
      row = {row[tmcg_pkg::PixelW-tmcg_pkg::ColorW-1:0], bits[7-i] ? fg : bg};
    end
    return row;
  endfunction

  function automatic bit write_takes_effect(input tmcg_pkg::action_e act,
                                            input int unsigned addr);
    if (act == tmcg_pkg::ACT_FONT) return addr < FONT_BYTES;
    return addr < CELLS;
  endfunction

  task automatic send_beat(input tmcg_pkg::action_e act,
                           input logic [tmcg_pkg::AddrW-1:0] addr,
                           input logic [tmcg_pkg::DataW-1:0] dat,
                           input logic [tmcg_pkg::LineW-1:0] ln,
                           input logic [tmcg_pkg::ColW-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    data_i     <= dat;
    line_i     <= ln;
    column_i   <= col;
    do @(posedge clk_i); while (!in_ready_o);
    case (act)
      tmcg_pkg::ACT_CHAR: begin
        if (addr < CELLS) begin
          code_mem[addr]     = dat;
          code_written[addr] = 1'b1;
        end
      end
      tmcg_pkg::ACT_ATTR: begin
        if (addr < CELLS) begin
          attr_mem[addr]     = dat;
          attr_written[addr] = 1'b1;
        end
      end
      tmcg_pkg::ACT_FONT: begin
        if (addr < FONT_BYTES) begin
          glyph_mem[addr]     = dat;
          glyph_written[addr] = 1'b1;
        end
      end
      default: begin
        pixel_rows_due.push_back(predict_pixel_row(ln, col));
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_byte(input tmcg_pkg::action_e act, input int unsigned addr,
                            input logic [tmcg_pkg::DataW-1:0] dat);
    send_beat(act, tmcg_pkg::AddrW'(addr), dat,
              tmcg_pkg::LineW'($urandom_range(MAX_LINE)),
              tmcg_pkg::ColW'($urandom_range(COLUMNS - 1)));
  endtask

  task automatic render_at(input int unsigned ln, input int unsigned col);
    send_beat(tmcg_pkg::ACT_RENDER, tmcg_pkg::AddrW'($urandom_range(MAX_ADDR)),
              tmcg_pkg::DataW'($urandom_range(255)), tmcg_pkg::LineW'(ln),
              tmcg_pkg::ColW'(col));
  endtask

  // Writes whatever the cell still lacks, so that the render reads only loaded entries.
  task automatic render_loaded(input int unsigned ln, input int unsigned col);
    int unsigned cell_idx;
    int unsigned glyph_addr;
    cell_idx = (ln / (2 * GLYPH_ROWS)) * COLUMNS + col;
    if (!code_written[cell_idx]) begin
      write_byte(tmcg_pkg::ACT_CHAR, cell_idx, tmcg_pkg::DataW'($urandom_range(255)));
    end
    if (!attr_written[cell_idx]) begin
      write_byte(tmcg_pkg::ACT_ATTR, cell_idx, tmcg_pkg::DataW'($urandom_range(255)));
    end
    glyph_addr = code_mem[cell_idx] * GLYPH_ROWS + (ln % (2 * GLYPH_ROWS)) / 2;
    if (!glyph_written[glyph_addr]) begin
      write_byte(tmcg_pkg::ACT_FONT, glyph_addr, tmcg_pkg::DataW'($urandom_range(255)));
    end
    render_at(ln, col);
  endtask

  task automatic test_first_and_last_cell();
    write_byte(tmcg_pkg::ACT_CHAR, 0, 8'h00);
    write_byte(tmcg_pkg::ACT_ATTR, 0, 8'h70);
    write_byte(tmcg_pkg::ACT_FONT, 0, 8'h81);
    write_byte(tmcg_pkg::ACT_FONT, GLYPH_ROWS - 1, 8'hFF);
    render_at(0, 0);
    render_at(1, 0);
    render_at(2 * GLYPH_ROWS - 2, 0);
    render_at(2 * GLYPH_ROWS - 1, 0);
    write_byte(tmcg_pkg::ACT_CHAR, CELLS - 1, 8'hFF);
    write_byte(tmcg_pkg::ACT_ATTR, CELLS - 1, 8'h8F);
    write_byte(tmcg_pkg::ACT_FONT, FONT_BYTES - 1, 8'hA5);
    render_at(LINES - 1, COLUMNS - 1);
    write_byte(tmcg_pkg::ACT_ATTR, 0, 8'h05);
    render_at(0, 0);
  endtask

  task automatic test_ignored_writes();
    write_byte(tmcg_pkg::ACT_CHAR, CELLS, 8'h55);
    write_byte(tmcg_pkg::ACT_ATTR, CELLS, 8'hAA);
    write_byte(tmcg_pkg::ACT_CHAR, MAX_ADDR, 8'h01);
    write_byte(tmcg_pkg::ACT_ATTR, MAX_ADDR, 8'h77);
    render_at(0, 0);
    render_at(LINES - 1, COLUMNS - 1);
  endtask

  task automatic test_offscreen_render();
    render_at(LINES, 0);
    render_at(MAX_LINE, COLUMNS - 1);
    render_at(LINES + 100, 7);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    int unsigned       done;
    int unsigned       pick;
    int unsigned       addr;
    tmcg_pkg::action_e act;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        render_loaded($urandom_range(LINES - 1), $urandom_range(COLUMNS - 1));
        done++;
      end else if (pick < 65) begin
        render_at($urandom_range(MAX_LINE, LINES), $urandom_range(COLUMNS - 1));
        done++;
      end else begin
        act = tmcg_pkg::action_e'($urandom_range(2));
        if (act == tmcg_pkg::ACT_FONT || $urandom_range(99) < 85) begin
          addr = $urandom_range((act == tmcg_pkg::ACT_FONT) ? FONT_BYTES - 1 : CELLS - 1);
        end else begin
          addr = $urandom_range(MAX_ADDR, CELLS);
        end
        write_byte(act, addr, tmcg_pkg::DataW'($urandom_range(255)));
        if (write_takes_effect(act, addr)) done++;
      end
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_rows_due.size() == 0) begin
        $error("pixel_row: no result expected, actual %h", pixel_row_o);
        mismatch_count++;
      end else begin
        logic [tmcg_pkg::PixelW-1:0] want;
        want = pixel_rows_due.pop_front();
        if (pixel_row_o !== want) begin
          $error("pixel_row: expected %h, actual %h", want, pixel_row_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     <= 1'b0;
    action_i       <= tmcg_pkg::ACT_CHAR;
    address_i      <= '0;
    data_i         <= '0;
    line_i         <= '0;
    column_i       <= '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_first_and_last_cell();
    test_ignored_writes();
    test_offscreen_render();
    test_random_traffic(0, 0, 70);
    test_random_traffic(66, 0, 70);
    test_random_traffic(0, 66, 70);
    test_random_traffic(17, 17, 70);

    in_valid_i <= 1'b0;
    while (pixel_rows_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tmcg_pkg.sv
rtl/tmcg_ram.sv
rtl/tmcg_rowdiv.sv
rtl/tmcg_expand.sv
rtl/text_mode_character_generator_top.sv
tb/testbench.sv
